>>> sv/sfd_pkg.sv
package sfd_pkg;

  // frame geometry
  localparam int FRAME_BYTES = 30;
  localparam int CNT_W = 6;
  localparam int ADDR_W = 5;

  localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_BYTES);
  localparam logic [CNT_W-1:0] HDR0_POS = CNT_W'(0);
  localparam logic [CNT_W-1:0] HDR1_POS = CNT_W'(1);
  localparam logic [CNT_W-1:0] SUM_FIRST_POS = CNT_W'(3);
  localparam logic [CNT_W-1:0] SUM_LAST_POS = CNT_W'(28);
  localparam logic [CNT_W-1:0] CHECK_POS = CNT_W'(29);

  // header bytes
  localparam logic [7:0] HDR0_BYTE = 8'h0d;
  localparam logic [7:0] HDR1_BYTE = 8'h0a;

  // decoded fields occupy frame bytes 4..28 back to back
  localparam logic [ADDR_W-1:0] FIELD_FIRST_ADDR = ADDR_W'(4);
  localparam logic [ADDR_W-1:0] COUNTER_LAST_ADDR = ADDR_W'(21);
  localparam logic [ADDR_W-1:0] STATUS0_ADDR = ADDR_W'(22);
  localparam logic [ADDR_W-1:0] STATUS1_ADDR = ADDR_W'(23);
  localparam logic [ADDR_W-1:0] STATUS2_ADDR = ADDR_W'(24);
  localparam logic [ADDR_W-1:0] FIELD_LAST_ADDR = ADDR_W'(28);

  localparam logic [3:0] FIRST_FIELD = 4'd0;
  localparam logic [3:0] FISCAL_FIELD = 4'd12;

  // frame memory write port from capture side
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } sfd_wr_t;

  // decode job handed from capture to decode
  typedef struct packed {
    logic checksum_error;
  } sfd_job_t;

endpackage

>>> sv/sfd_front.sv
module sfd_front
  import sfd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     in_cmd_i,
  input  logic [7:0] in_data_byte_i,
  input  logic     back_busy_i,
  input  logic     fifo_empty_i,
  input  logic     fifo_full_i,
  output logic     fifo_push_o,
  output sfd_job_t fifo_job_o,
  output sfd_wr_t  mem_wr_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       sum_q, sum_d;
  logic             hdr_ok_q, hdr_ok_d;
  logic             frame_done;
  logic             accept;
  logic             capture;

  // a restart must wait until the decode of the finished frame has read the store
  assign frame_done = (cnt_q == FRAME_CNT);
  assign in_stall_o = frame_done && (back_busy_i || !fifo_empty_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign capture    = accept && !in_cmd_i && (cnt_q < FRAME_CNT);

  // frame store write
  assign mem_wr_o.en   = capture;
  assign mem_wr_o.addr = cnt_q[ADDR_W-1:0];
  assign mem_wr_o.data = in_data_byte_i;

  // classification at the last byte
  assign fifo_push_o = capture && (cnt_q == CHECK_POS) && hdr_ok_q && !fifo_full_i;
  assign fifo_job_o.checksum_error = (in_data_byte_i != sum_q);

  // count, checksum and header tracking
  always_comb begin
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    hdr_ok_d = hdr_ok_q;
    if (accept && in_cmd_i) begin
      cnt_d = '0;
      sum_d = '0;
    end else if (capture) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q inside {[SUM_FIRST_POS:SUM_LAST_POS]}) begin
        sum_d = sum_q + in_data_byte_i;
      end
      if (cnt_q == HDR0_POS) begin
        hdr_ok_d = (in_data_byte_i == HDR0_BYTE);
      end else if (cnt_q == HDR1_POS) begin
        hdr_ok_d = hdr_ok_q && (in_data_byte_i == HDR1_BYTE);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sum_q    <= '0;
      hdr_ok_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      sum_q    <= sum_d;
      hdr_ok_q <= hdr_ok_d;
    end
  end

`ifndef SYNTH
  // the store is never written while a decode may still read it
  a_no_write_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr_o.en |-> !back_busy_i && fifo_empty_i)
    else $error("frame store written during decode");

  // a completed frame with a good header always reaches the queue
  a_push_not_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (capture && (cnt_q == CHECK_POS) && hdr_ok_q) |-> !fifo_full_i)
    else $error("decode job lost on full queue");
`endif

endmodule

>>> sv/sfd_fifo.sv
module sfd_fifo
  import sfd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  sfd_job_t push_data_i,
  input  logic     pop_i,
  output sfd_job_t pop_data_o,
  output logic     empty_o,
  output logic     full_o
);

  sfd_job_t   slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push;
  logic       do_pop;

  assign empty_o    = (count_q == 2'd0);
  assign full_o     = (count_q == 2'd2);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = slot_q[rd_ptr_q];

  // job slots
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

>>> sv/sfd_back.sv
module sfd_back
  import sfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_expected_fiscal_id_i,
  input  sfd_wr_t     mem_wr_i,
  input  logic        fifo_empty_i,
  input  sfd_job_t    fifo_job_i,
  output logic        fifo_pop_o,
  output logic        busy_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  out_field_index_o,
  output logic [31:0] out_field_value_o,
  output logic        out_checksum_error_o,
  output logic        out_fiscal_match_o,
  output logic        out_last_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_ACC  = 2'd2;

  logic [7:0]        mem_q [FRAME_BYTES];
  logic [7:0]        rd_data_q;
  logic              rd_en;
  logic [1:0]        state_q, state_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [3:0]        field_q, field_d;
  logic [31:0]       acc_q, acc_d;
  logic [31:0]       word;
  logic [31:0]       expected_q;
  logic              out_free;
  logic              load;
  logic              out_valid_q;
  logic [3:0]        idx_q, idx_d;
  logic [31:0]       val_q, val_d;
  logic              err_q, err_d;
  logic              match_q, match_d;
  logic              last_q, last_d;

  // true at the final byte of each field
  function automatic logic field_end(input logic [ADDR_W-1:0] a);
    logic r;
    r = 1'b0;
    if (a inside {STATUS0_ADDR, STATUS1_ADDR, STATUS2_ADDR, FIELD_LAST_ADDR}) begin
      r = 1'b1;
    end else if ((a <= COUNTER_LAST_ADDR) && a[0]) begin
      r = 1'b1;
    end
    return r;
  endfunction

  // pending fiscal id
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q <= '0;
    end else if (cfg_we_i) begin
      expected_q <= cfg_expected_fiscal_id_i;
    end
  end

  // frame store, one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_wr_i.en) begin
      mem_q[mem_wr_i.addr] <= mem_wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[addr_q];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign word     = {acc_q[23:0], rd_data_q};
  assign busy_o   = (state_q != S_IDLE);
  assign rd_en    = (state_q == S_READ);

  // decode sequencer walks the field bytes in order
  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    field_d    = field_q;
    acc_d      = acc_q;
    fifo_pop_o = 1'b0;
    load       = 1'b0;
    idx_d      = idx_q;
    val_d      = val_q;
    err_d      = err_q;
    match_d    = match_q;
    last_d     = last_q;
    case (state_q)
      S_IDLE: begin
        if (!fifo_empty_i) begin
          if (fifo_job_i.checksum_error) begin
            if (out_free) begin
              fifo_pop_o = 1'b1;
              load       = 1'b1;
              idx_d      = FIRST_FIELD;
              val_d      = '0;
              err_d      = 1'b1;
              match_d    = 1'b0;
              last_d     = 1'b1;
            end
          end else begin
            fifo_pop_o = 1'b1;
            addr_d     = FIELD_FIRST_ADDR;
            field_d    = FIRST_FIELD;
            acc_d      = '0;
            state_d    = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        if (field_end(addr_q)) begin
          if (out_free) begin
            load    = 1'b1;
            idx_d   = field_q;
            val_d   = word;
            err_d   = 1'b0;
            match_d = (field_q == FISCAL_FIELD) && (word == expected_q);
            last_d  = (field_q == FISCAL_FIELD);
            acc_d   = '0;
            field_d = field_q + 4'd1;
            if (addr_q == FIELD_LAST_ADDR) begin
              state_d = S_IDLE;
            end else begin
              addr_d  = addr_q + ADDR_W'(1);
              state_d = S_READ;
            end
          end
        end else begin
          acc_d   = word;
          addr_d  = addr_q + ADDR_W'(1);
          state_d = S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    field_q <= field_d;
    acc_q   <= acc_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    val_q   <= val_d;
    err_q   <= err_d;
    match_q <= match_d;
    last_q  <= last_d;
  end

  assign out_valid_o          = out_valid_q;
  assign out_field_index_o    = idx_q;
  assign out_field_value_o    = val_q;
  assign out_checksum_error_o = err_q;
  assign out_fiscal_match_o   = match_q;
  assign out_last_o           = last_q;

`ifndef SYNTH
  // a stalled result is never overwritten by a new one
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");

  // the fiscal id closes a good frame
  a_last_is_fiscal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_last_o && !out_checksum_error_o) |->
      (out_field_index_o == FISCAL_FIELD))
    else $error("good frame closed by a field other than the fiscal id");

  // the match flag only rides on the fiscal id
  a_match_on_fiscal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_fiscal_match_o) |-> (out_field_index_o == FISCAL_FIELD))
    else $error("fiscal match on wrong field");

  // every read is followed by its accumulate step
  a_read_then_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> (state_q == S_ACC))
    else $error("read data not consumed");
`endif

endmodule

>>> sv/status_frame_deframer.sv
// Status frame deframer: received serial bytes (cmd 0) are captured one per cycle into a
// 30-byte frame store; a restart request (cmd 1) clears the capture. At the 30th byte a
// frame that starts with 0x0d 0x0a is checked against the 8-bit sum of bytes 3..28 in
// byte 29, and queued for decode: a failed check yields one error result, a good frame
// yields thirteen big-endian fields (nine 16-bit counters, three status bytes, the 32-bit
// fiscal id with a match flag against the configured pending id). Frames with a bad header
// yield nothing, and bytes after the 30th are dropped until the next restart. Decode reads
// the store byte by byte, setting the address in S_READ and taking the registered read
// data in S_ACC; output stalls can hold it at the end of each field. A restart request is
// held off by in_stall_o until that decode has finished reading the store. The user must
// write the pending fiscal id through cfg_we_i only while idle; the block does not
// enforce this.
module status_frame_deframer
  import sfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_expected_fiscal_id_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_cmd_i,
  input  logic [7:0]  in_data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  out_field_index_o,
  output logic [31:0] out_field_value_o,
  output logic        out_checksum_error_o,
  output logic        out_fiscal_match_o,
  output logic        out_last_o
);

  sfd_wr_t  mem_wr;
  sfd_job_t push_job;
  sfd_job_t pop_job;
  logic     push;
  logic     pop;
  logic     fifo_empty;
  logic     fifo_full;
  logic     back_busy;

  // capture and classification
  sfd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_cmd_i       (in_cmd_i),
    .in_data_byte_i (in_data_byte_i),
    .back_busy_i    (back_busy),
    .fifo_empty_i   (fifo_empty),
    .fifo_full_i    (fifo_full),
    .fifo_push_o    (push),
    .fifo_job_o     (push_job),
    .mem_wr_o       (mem_wr)
  );

  // decode job queue
  sfd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (fifo_empty),
    .full_o      (fifo_full)
  );

  // field decode and result output
  sfd_back u_back (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_we_i                 (cfg_we_i),
    .cfg_expected_fiscal_id_i (cfg_expected_fiscal_id_i),
    .mem_wr_i                 (mem_wr),
    .fifo_empty_i             (fifo_empty),
    .fifo_job_i               (pop_job),
    .fifo_pop_o               (pop),
    .busy_o                   (back_busy),
    .out_valid_o              (out_valid_o),
    .out_stall_i              (out_stall_i),
    .out_field_index_o        (out_field_index_o),
    .out_field_value_o        (out_field_value_o),
    .out_checksum_error_o     (out_checksum_error_o),
    .out_fiscal_match_o       (out_fiscal_match_o),
    .out_last_o               (out_last_o)
  );

endmodule
